[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the block clock and reset.
`define ASSERT_ON(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[rtl/bpu_pkg.sv]
`default_nettype none

package bpu_pkg;

  // Wide enough for any clamped dimension limit.
  localparam int unsigned DIM_W = 15;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Row stride rounding to a 32-bit boundary.
  localparam int unsigned STRIDE_ROUND = 31;

  localparam logic [4:0] BPP_1  = 5'd1;
  localparam logic [4:0] BPP_4  = 5'd4;
  localparam logic [4:0] BPP_8  = 5'd8;
  localparam logic [4:0] BPP_24 = 5'd24;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP,
    REG_WIDTH,
    REG_HEIGHT,
    REG_ROTATION,
    REG_TRANSPARENT,
    REG_START_X,
    REG_START_Y
  } cfg_reg_e;

  typedef struct packed {
    logic [4:0]  bits_per_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [1:0]  rotation;
    logic        transparent;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } cfg_t;

  // One palette access per cycle, write or read.
  typedef struct packed {
    logic        we;
    logic        re;
    logic [7:0]  addr;
    logic [23:0] wdata;
  } mem_req_t;

  // Flags of a pixel leaving the unpack sequencer.
  typedef struct packed {
    logic vld;
    logic last;
    logic direct;
    logic zero;
  } tok_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [12:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] v_ext;
    v_ext = DIM_W'(v);
    if (v == 13'd0) begin
      return DIM_W'(1);
    end else if (v_ext > hi) begin
      return hi;
    end
    return v_ext;
  endfunction

endpackage

`default_nettype wire

[rtl/bpu_cfg_regs.sv]
`default_nettype none

module bpu_cfg_regs import bpu_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BPP:         cfg_d.bits_per_pixel = cfg_wdata_i[4:0];
        REG_WIDTH:       cfg_d.image_width    = cfg_wdata_i[12:0];
        REG_HEIGHT:      cfg_d.image_height   = cfg_wdata_i[12:0];
        REG_ROTATION:    cfg_d.rotation       = cfg_wdata_i[1:0];
        REG_TRANSPARENT: cfg_d.transparent    = cfg_wdata_i[0];
        REG_START_X:     cfg_d.start_x        = cfg_wdata_i;
        REG_START_Y:     cfg_d.start_y        = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bits_per_pixel <= BPP_1;
      cfg_q.image_width    <= 13'd1;
      cfg_q.image_height   <= 13'd1;
      cfg_q.rotation       <= ROT_0;
      cfg_q.transparent    <= 1'b0;
      cfg_q.start_x        <= 16'd0;
      cfg_q.start_y        <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/bpu_palette_mem.sv]
`default_nettype none

module bpu_palette_mem import bpu_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire          clk_i,
  input  mem_req_t     req_i,
  output logic [23:0]  rd_data_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  logic [23:0] mem [PALETTE_DEPTH];
  logic [23:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr[AW-1:0]] <= req_i.wdata;
    end
    // Hold read data unless a new read is issued.
    if (req_i.re) begin
      rd_q <= mem[req_i.addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

[rtl/bpu_unpack.sv]
`default_nettype none

module bpu_unpack import bpu_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned MAX_HEIGHT    = 4096,
  parameter int unsigned PALETTE_DEPTH = 256,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cfg_t              cfg_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               command_i,
  input  wire [7:0]         palette_index_i,
  input  wire [23:0]        palette_color_i,
  input  wire [7:0]         data_byte_i,
  input  wire               adv_i,
  output mem_req_t          mreq_o,
  output tok_t              tok_o,
  output logic [WW-1:0]     tok_col_o,
  output logic [RW-1:0]     tok_row_o,
  output logic [23:0]       tok_rgb_o
);

  localparam int unsigned SMAX = ((MAX_WIDTH * 24 + 31) / 32) * 4;
  localparam int unsigned BW   = $clog2(SMAX + 1);
  localparam int unsigned SW   = WW + 5;
  localparam int unsigned NW   = (WW > 4) ? WW : 4;

  typedef enum logic [1:0] {
    PH_BLUE,
    PH_GREEN,
    PH_RED
  } phase_e;

  logic [DIM_W-1:0] w_clamp, h_clamp;
  logic [WW-1:0]    w;
  logic [RW-1:0]    h;
  logic             bpp_ok, is_24;
  logic [3:0]       per;
  logic [SW-1:0]    prod, sum;
  logic [BW-1:0]    stride, bir_inc;
  logic             in_row;
  logic [WW-1:0]    rem;
  logic [NW-1:0]    rem_ext, per_ext;
  logic [3:0]       n, npix, emit_cnt;
  logic [RW-1:0]    row_inc;
  logic             accept, load, step, done, wr_ok;

  logic [WW-1:0] pir_q, pir_d;
  logic [BW-1:0] bir_q, bir_d;
  logic [RW-1:0] row_q, row_d;
  logic [15:0]   hold_q, hold_d;
  phase_e        phase_q, phase_d;

  // Sequencer stage
  logic          s0_vld_q, s0_vld_d;
  logic          s0_wr_q;
  logic [3:0]    s0_rem_q;
  logic [7:0]    s0_sh_q, sh_next;
  logic [WW-1:0] s0_col_q;
  logic [RW-1:0] s0_row_q;
  logic [23:0]   s0_rgb_q;
  logic [7:0]    s0_addr_q;
  logic [7:0]    idx;

  assign w_clamp = clamp_dim(cfg_i.image_width, DIM_W'(MAX_WIDTH));
  assign h_clamp = clamp_dim(cfg_i.image_height, DIM_W'(MAX_HEIGHT));
  assign w = w_clamp[WW-1:0];
  assign h = h_clamp[RW-1:0];

  assign is_24  = (cfg_i.bits_per_pixel == BPP_24);
  assign bpp_ok = (cfg_i.bits_per_pixel == BPP_1) || (cfg_i.bits_per_pixel == BPP_4) ||
                  (cfg_i.bits_per_pixel == BPP_8) || is_24;

  always_comb begin
    case (cfg_i.bits_per_pixel)
      BPP_1: begin
        per  = 4'd8;
        prod = SW'(w);
      end
      BPP_4: begin
        per  = 4'd2;
        prod = SW'(w) << 2;
      end
      BPP_8: begin
        per  = 4'd1;
        prod = SW'(w) << 3;
      end
      default: begin
        per  = 4'd1;
        prod = (SW'(w) << 4) + (SW'(w) << 3);
      end
    endcase
  end

  assign sum     = prod + SW'(STRIDE_ROUND);
  assign stride  = BW'({sum[SW-1:5], 2'b00});
  assign in_row  = (pir_q < w);
  assign rem     = w - pir_q;
  assign rem_ext = NW'(rem);
  assign per_ext = NW'(per);
  assign n       = !in_row ? 4'd0 : ((rem_ext < per_ext) ? rem_ext[3:0] : per);
  assign bir_inc = bir_q + BW'(1);
  assign row_inc = row_q + RW'(1);

  assign done       = adv_i && s0_vld_q && (s0_wr_q || (s0_rem_q == 4'd1));
  assign in_ready_o = !s0_vld_q || done;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_ok      = ({1'b0, palette_index_i} < 9'(PALETTE_DEPTH));

  // Counter and 24-bit assembly update when a data byte of a supported depth is accepted.
  always_comb begin
    pir_d   = pir_q;
    bir_d   = bir_q;
    row_d   = row_q;
    hold_d  = hold_q;
    phase_d = phase_q;
    npix    = 4'd0;
    if (accept && (command_i == CMD_DATA) && bpp_ok) begin
      if (is_24) begin
        if (in_row) begin
          case (phase_q)
            PH_BLUE: begin
              hold_d  = {8'h00, data_byte_i};
              phase_d = PH_GREEN;
            end
            PH_GREEN: begin
              hold_d  = {data_byte_i, hold_q[7:0]};
              phase_d = PH_RED;
            end
            default: begin
              npix    = 4'd1;
              pir_d   = pir_q + WW'(1);
              phase_d = PH_BLUE;
            end
          endcase
        end
      end else begin
        npix  = n;
        pir_d = pir_q + WW'(n);
      end
      if (bir_inc >= stride) begin
        bir_d   = '0;
        pir_d   = '0;
        phase_d = PH_BLUE;
        row_d   = (row_inc >= h) ? '0 : row_inc;
      end else begin
        bir_d = bir_inc;
      end
    end
  end

  assign emit_cnt = cfg_i.transparent ? 4'd0 : npix;
  assign load = accept && (((command_i == CMD_PALETTE) && wr_ok) ||
                           ((command_i == CMD_DATA) && (emit_cnt != 4'd0)));
  assign step = adv_i && s0_vld_q && !s0_wr_q;

  always_comb begin
    if (load) begin
      s0_vld_d = 1'b1;
    end else if (done) begin
      s0_vld_d = 1'b0;
    end else begin
      s0_vld_d = s0_vld_q;
    end
  end

  // Palette index from the top of the shifted byte.
  always_comb begin
    case (cfg_i.bits_per_pixel)
      BPP_1: begin
        idx     = {7'd0, s0_sh_q[7]};
        sh_next = s0_sh_q << 1;
      end
      BPP_4: begin
        idx     = {4'd0, s0_sh_q[7:4]};
        sh_next = s0_sh_q << 4;
      end
      default: begin
        idx     = s0_sh_q;
        sh_next = s0_sh_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pir_q    <= '0;
      bir_q    <= '0;
      row_q    <= '0;
      hold_q   <= '0;
      phase_q  <= PH_BLUE;
      s0_vld_q <= 1'b0;
    end else begin
      pir_q    <= pir_d;
      bir_q    <= bir_d;
      row_q    <= row_d;
      hold_q   <= hold_d;
      phase_q  <= phase_d;
      s0_vld_q <= s0_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s0_wr_q   <= (command_i == CMD_PALETTE);
      s0_rem_q  <= emit_cnt;
      s0_sh_q   <= data_byte_i;
      s0_col_q  <= pir_q;
      s0_row_q  <= row_q;
      s0_rgb_q  <= (command_i == CMD_PALETTE) ? palette_color_i :
                   {data_byte_i, hold_q};
      s0_addr_q <= palette_index_i;
    end else if (step) begin
      s0_rem_q <= s0_rem_q - 4'd1;
      s0_sh_q  <= sh_next;
      s0_col_q <= s0_col_q + WW'(1);
    end
  end

  always_comb begin
    mreq_o.we    = adv_i && s0_vld_q && s0_wr_q;
    mreq_o.re    = step && !is_24;
    mreq_o.addr  = s0_wr_q ? s0_addr_q : idx;
    mreq_o.wdata = s0_rgb_q;
  end

  assign tok_o.vld    = s0_vld_q && !s0_wr_q;
  assign tok_o.last   = (s0_rem_q == 4'd1);
  assign tok_o.direct = is_24;
  assign tok_o.zero   = ({1'b0, idx} >= 9'(PALETTE_DEPTH));
  assign tok_col_o    = s0_col_q;
  assign tok_row_o    = s0_row_q;
  assign tok_rgb_o    = s0_rgb_q;

endmodule

`default_nettype wire

[rtl/bpu_place.sv]
`default_nettype none

module bpu_place import bpu_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cfg_t               cfg_i,
  input  tok_t               tok_i,
  input  wire [WW-1:0]       tok_col_i,
  input  wire [RW-1:0]       tok_row_i,
  input  wire [23:0]         tok_rgb_i,
  input  wire [23:0]         rd_data_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [16:0] pixel_x_o,
  output logic signed [16:0] pixel_y_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic               last_of_item_o
);

  logic [DIM_W-1:0] w_clamp, h_clamp;

  // Stage aligned with palette read data
  logic          s1_vld_q;
  logic          s1_last_q, s1_direct_q, s1_zero_q;
  logic [WW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic [23:0]   s1_rgb_q;

  logic [23:0] rgb;
  logic [16:0] c17, r17, w17, h17, xr, yr, sx, sy;

  logic        out_vld_q;
  logic [16:0] x_q, y_q;
  logic [23:0] rgb_q;
  logic        last_q;

  assign adv_o = !out_vld_q || out_ready_i;

  assign w_clamp = clamp_dim(cfg_i.image_width, DIM_W'(MAX_WIDTH));
  assign h_clamp = clamp_dim(cfg_i.image_height, DIM_W'(MAX_HEIGHT));
  assign w17 = 17'(w_clamp);
  assign h17 = 17'(h_clamp);
  assign c17 = 17'(s1_col_q);
  assign r17 = 17'(s1_row_q);
  assign sx  = {cfg_i.start_x[15], cfg_i.start_x};
  assign sy  = {cfg_i.start_y[15], cfg_i.start_y};

  assign rgb = s1_direct_q ? s1_rgb_q : (s1_zero_q ? 24'd0 : rd_data_i);

  always_comb begin
    case (cfg_i.rotation)
      ROT_90: begin
        xr = h17 - r17;
        yr = c17;
      end
      ROT_180: begin
        xr = w17 - c17;
        yr = h17 - r17;
      end
      ROT_270: begin
        xr = r17;
        yr = w17 - c17;
      end
      default: begin
        xr = c17;
        yr = r17;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      s1_vld_q  <= tok_i.vld;
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s1_last_q   <= tok_i.last;
      s1_direct_q <= tok_i.direct;
      s1_zero_q   <= tok_i.zero;
      s1_col_q    <= tok_col_i;
      s1_row_q    <= tok_row_i;
      s1_rgb_q    <= tok_rgb_i;
      x_q         <= xr + sx;
      y_q         <= yr + sy;
      rgb_q       <= rgb;
      last_q      <= s1_last_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pixel_x_o      = x_q;
  assign pixel_y_o      = y_q;
  assign red_o          = rgb_q[23:16];
  assign green_o        = rgb_q[15:8];
  assign blue_o         = rgb_q[7:0];
  assign last_of_item_o = last_q;

endmodule

`default_nettype wire

[rtl/bitmap_pixel_unpack_rotate_top.sv]
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
// in        in         in_valid_i / in_ready_o   command_i, palette_index_i,
//                                                palette_color_i, data_byte_i
// out       out        out_valid_o / out_ready_i pixel_x_o, pixel_y_o, red_o,
//                                                green_o, blue_o, last_of_item_o
//
// A data byte holds the unpack sequencer while it emits one pixel per cycle, stalls
// apart (1 to 8, eight at one bit per pixel); a palette write is one palette port access.
// Bytes that emit nothing are taken one per cycle while the sequencer is free. A pixel
// passes the sequencer stage, palette read stage and placement register to the output.
// Reset clears counters, restores config defaults; palette is undefined until written.
// A stalled output holds the pixel pipeline; requests enter when the sequencer is free.
`default_nettype none

module bitmap_pixel_unpack_rotate_top import bpu_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned MAX_HEIGHT    = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire                  command_i,
  input  wire [7:0]            palette_index_i,
  input  wire [23:0]           palette_color_i,
  input  wire [7:0]            data_byte_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic signed [16:0]   pixel_x_o,
  output logic signed [16:0]   pixel_y_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic                 last_of_item_o
);

`include "assert_macros.svh"

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

  cfg_t          cfg;
  mem_req_t      mem_req;
  tok_t          tok;
  logic [WW-1:0] tok_col;
  logic [RW-1:0] tok_row;
  logic [23:0]   tok_rgb;
  logic [23:0]   rd_data;
  logic          adv;

  bpu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bpu_unpack #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .palette_index_i (palette_index_i),
    .palette_color_i (palette_color_i),
    .data_byte_i     (data_byte_i),
    .adv_i           (adv),
    .mreq_o          (mem_req),
    .tok_o           (tok),
    .tok_col_o       (tok_col),
    .tok_row_o       (tok_row),
    .tok_rgb_o       (tok_rgb)
  );

  bpu_palette_mem #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  bpu_place #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_place (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .tok_i          (tok),
    .tok_col_i      (tok_col),
    .tok_row_i      (tok_row),
    .tok_rgb_i      (tok_rgb),
    .rd_data_i      (rd_data),
    .adv_o          (adv),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .last_of_item_o (last_of_item_o)
  );

  `ASSERT_ON(a_pal_single_access, !(mem_req.we && mem_req.re), "palette read and write collide")
  `ASSERT_ON(a_pal_idle_on_stall, (out_valid_o && !out_ready_i) |-> !(mem_req.we || mem_req.re), "palette accessed while output stalled")
  `ASSERT_ON(a_read_has_token, mem_req.re |-> (tok.vld && !tok.direct), "palette read without indexed pixel")

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bpu_pkg::*;

  localparam int unsigned MAX_W = 4096;
  localparam int unsigned MAX_H = 4096;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRESSURE_CYCLES = 400;
  localparam logic [4:0] BPP_NONE = 5'd0;
  localparam logic [4:0] BPP_ODD = 5'd2;
  localparam logic [4:0] BPP_MAX = 5'd31;

  typedef struct {
    logic        cmd;
    logic [7:0]  pal_idx;
    logic [23:0] pal_color;
    logic [7:0]  data;
  } bmp_req_t;

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic               last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_reg_e    cfg_idx;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [7:0]  pal_index;
  logic [23:0] pal_color;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic signed [16:0] pix_x;
  logic signed [16:0] pix_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_px;

  bitmap_pixel_unpack_rotate_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .palette_index_i(pal_index),
    .palette_color_i(pal_color),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_x_o      (pix_x),
    .pixel_y_o      (pix_y),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .last_of_item_o (last_px)
  );

  // Mirror of the block's registers and counters
  logic [4:0]  bpp_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  rot_q;
  logic        transp_q;
  logic [15:0] xoff_q;
  logic [15:0] yoff_q;
  logic [23:0] palette_mem [256];
  int unsigned row_idx;
  int unsigned col_idx;
  int unsigned byte_idx;
  logic [15:0] rgb_hold;
  logic [1:0]  rgb_phase;

  bmp_req_t req_pending [$];
  pixel_t   pixel_expect [$];
  pixel_t   got;
  pixel_t   want;

  logic req_taken;
  logic idle_off;
  logic pressure_go;
  logic pressure_done;
  int   gap_left;
  int   stall_left;
  int   err_count;
  int   n_reqs;
  int   n_pal;
  int   n_pixels;
  int   n_setups;

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic int unsigned dim_limit(input logic [12:0] v, input int unsigned hi);
    if (v == 13'd0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pixel_t place_pixel(input int col, input logic [23:0] rgb);
    pixel_t p;
    int w;
    int h;
    int r;
    int x;
    int y;
    w = dim_limit(width_q, MAX_W);
    h = dim_limit(height_q, MAX_H);
    r = row_idx;
    case (rot_q)
      ROT_90: begin
        x = h - r;
        y = col;
      end
      ROT_180: begin
        x = w - col;
        y = h - r;
      end
      ROT_270: begin
        x = r;
        y = w - col;
      end
      default: begin
        x = col;
        y = r;
      end
    endcase
    x = x + $signed(xoff_q);
    y = y + $signed(yoff_q);
    p.x = x[16:0];
    p.y = y[16:0];
    p.r = rgb[23:16];
    p.g = rgb[15:8];
    p.b = rgb[7:0];
    p.last = 1'b0;
    return p;
  endfunction

  // Expected pixels for one accepted request, appended to pixel_expect
  function automatic void predict_request(input bmp_req_t q);
    pixel_t burst [8];
    int cnt;
    int unsigned w;
    int unsigned h;
    int unsigned stride;
    int unsigned per;
    int unsigned n;
    logic [7:0] mask;
    logic [7:0] idx;
    cnt = 0;
    if (q.cmd == CMD_PALETTE) begin
      palette_mem[q.pal_idx] = q.pal_color;
      return;
    end
    if (bpp_q != BPP_1 && bpp_q != BPP_4 && bpp_q != BPP_8 && bpp_q != BPP_24) return;
    w = dim_limit(width_q, MAX_W);
    h = dim_limit(height_q, MAX_H);
    stride = ((w * bpp_q + 31) >> 5) * 4;
    if (bpp_q == BPP_24) begin
      if (col_idx < w) begin
        case (rgb_phase)
          2'd0: begin
            rgb_hold = {8'h00, q.data};
            rgb_phase = 2'd1;
          end
          2'd1: begin
            rgb_hold = {q.data, rgb_hold[7:0]};
            rgb_phase = 2'd2;
          end
          default: begin
            if (!transp_q) begin
              burst[cnt] = place_pixel(col_idx, {q.data, rgb_hold});
              cnt++;
            end
            col_idx++;
            rgb_phase = 2'd0;
          end
        endcase
      end
    end else begin
      per = 8 / bpp_q;
      mask = 8'hFF >> (8 - bpp_q);
      for (n = 0; n < per && col_idx < w; n++) begin
        idx = (q.data >> (8 - (n + 1) * bpp_q)) & mask;
        if (!transp_q) begin
          burst[cnt] = place_pixel(col_idx, palette_mem[idx]);
          cnt++;
        end
        col_idx++;
      end
    end
    byte_idx++;
    if (byte_idx >= stride) begin
      byte_idx = 0;
      col_idx = 0;
      rgb_phase = 2'd0;
      row_idx++;
      if (row_idx >= h) row_idx = 0;
    end
    if (cnt > 0) burst[cnt-1].last = 1'b1;
    for (int k = 0; k < cnt; k++) pixel_expect.push_back(burst[k]);
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !req_taken)) begin
      if (in_valid) gap_left = idle_off ? 0 : pick_gap();
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_pending.size() != 0) begin
        command   <= req_pending[0].cmd;
        pal_index <= req_pending[0].pal_idx;
        pal_color <= req_pending[0].pal_color;
        data_byte <= req_pending[0].data;
        in_valid  <= 1'b1;
        void'(req_pending.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Pixel receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (pressure_go && !pressure_done) begin
        stall_left = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: track register writes, predict on accepted requests, check pixels
  always @(posedge clk) begin
    req_taken = rst_n && in_valid && in_ready;
    if (req_taken) begin
      n_reqs++;
      if (command == CMD_PALETTE) n_pal++;
      predict_request('{command, pal_index, pal_color, data_byte});
    end
    if (rst_n && cfg_we) begin
      case (cfg_idx)
        REG_BPP:         bpp_q = cfg_wdata[4:0];
        REG_WIDTH:       width_q = cfg_wdata[12:0];
        REG_HEIGHT:      height_q = cfg_wdata[12:0];
        REG_ROTATION:    rot_q = cfg_wdata[1:0];
        REG_TRANSPARENT: transp_q = cfg_wdata[0];
        REG_START_X:     xoff_q = cfg_wdata;
        REG_START_Y:     yoff_q = cfg_wdata;
        default: ;
      endcase
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{pix_x, pix_y, red, green, blue, last_px};
      n_pixels++;
      if (pixel_expect.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected pixel x=%0d y=%0d rgb=%02h%02h%02h last=%b",
                   got.x, got.y, got.r, got.g, got.b, got.last);
      end else begin
        want = pixel_expect.pop_front();
        if (got.x != want.x || got.y != want.y || got.r != want.r ||
            got.g != want.g || got.b != want.b || got.last != want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("pixel mismatch: expected x=%0d y=%0d rgb=%02h%02h%02h last=%b, got x=%0d y=%0d rgb=%02h%02h%02h last=%b",
                     want.x, want.y, want.r, want.g, want.b, want.last,
                     got.x, got.y, got.r, got.g, got.b, got.last);
        end
      end
    end
  end

  task automatic push_data(input logic [7:0] b);
    req_pending.push_back('{CMD_DATA, 8'h00, 24'h000000, b});
  endtask

  task automatic push_palette(input logic [7:0] idx, input logic [23:0] color);
    req_pending.push_back('{CMD_PALETTE, idx, color, 8'h00});
  endtask

  // Hold until every request is taken and every pixel is back, then let the
  // pipeline drain bytes that produced nothing
  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (req_pending.size() != 0 || in_valid || pixel_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [4:0] bpp, input logic [12:0] w,
                            input logic [12:0] h, input logic [1:0] rot,
                            input logic transp, input logic [15:0] sx,
                            input logic [15:0] sy);
    wait_idle();
    write_reg(REG_BPP, 16'(bpp));
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    write_reg(REG_ROTATION, 16'(rot));
    write_reg(REG_TRANSPARENT, 16'(transp));
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    n_setups++;
  endtask

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    #(4_000_000);
    $display("[bitmap_pixel_unpack_rotate_top] ERROR");
    $finish;
  end

  initial begin
    logic [4:0]  bpp;
    logic [12:0] w;
    logic [12:0] h;
    int sel;
    int n_items;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_BPP;
    cfg_wdata = 16'h0000;
    in_valid = 1'b0;
    command = CMD_DATA;
    pal_index = 8'h00;
    pal_color = 24'h000000;
    data_byte = 8'h00;
    out_ready = 1'b0;
    req_taken = 1'b0;
    idle_off = 1'b0;
    pressure_go = 1'b0;
    pressure_done = 1'b0;
    gap_left = 0;
    stall_left = 0;
    err_count = 0;
    n_reqs = 0;
    n_pal = 0;
    n_pixels = 0;
    n_setups = 0;
    bpp_q = BPP_1;
    width_q = 13'd1;
    height_q = 13'd1;
    rot_q = ROT_0;
    transp_q = 1'b0;
    xoff_q = 16'h0000;
    yoff_q = 16'h0000;
    row_idx = 0;
    col_idx = 0;
    byte_idx = 0;
    rgb_hold = 16'h0000;
    rgb_phase = 2'd0;
    foreach (palette_mem[i]) palette_mem[i] = 24'h000000;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the low 32 palette entries; 8-bit bytes stay below 32 so no lookup
    // ever hits an unwritten entry
    push_palette(8'd0, 24'h000000);
    push_palette(8'd1, 24'hFFFFFF);
    for (int i = 2; i < 32; i++) push_palette(8'(i), 24'($urandom_range(0, 24'hFFFFFF)));

    // Reset settings: one pixel per row, single-row image wrapping every stride
    push_data(8'h80);
    push_data(8'hFF);
    push_data(8'h00);
    push_data(8'h55);
    push_data(8'h00);

    set_config(BPP_4, 13'd3, 13'd2, ROT_90, 1'b0, 16'h7FFF, 16'h8000);
    push_data(8'h0F);
    push_data(8'hF0);
    push_data(8'hAB);
    push_data(8'hCD);
    push_data(8'h12);

    // Zero width and oversized height clamp
    set_config(BPP_8, 13'd0, 13'd8191, ROT_180, 1'b0, 16'h8000, 16'h7FFF);
    push_data(8'h1F);
    push_data(8'h00);
    push_data(8'h1E);

    set_config(BPP_24, 13'd2, 13'd2, ROT_270, 1'b0, 16'h0000, 16'h0000);
    push_data(8'h11);
    push_data(8'h22);
    push_data(8'h33);
    push_data(8'hFF);
    push_data(8'h00);
    push_data(8'hAA);
    push_data(8'h01);
    push_data(8'h02);

    // Unsupported depths drop data entirely
    set_config(BPP_ODD, 13'd4, 13'd2, ROT_0, 1'b0, 16'h0000, 16'h0000);
    push_data(8'hFF);
    push_data(8'h00);
    set_config(BPP_NONE, 13'd4, 13'd2, ROT_0, 1'b0, 16'h0000, 16'h0000);
    push_data(8'hAA);
    set_config(BPP_MAX, 13'd4, 13'd2, ROT_0, 1'b0, 16'h0000, 16'h0000);
    push_data(8'h55);

    set_config(BPP_1, 13'd16, 13'd1, ROT_0, 1'b1, 16'h0000, 16'h0000);
    push_data(8'hFF);
    push_data(8'h0F);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        // Long stall on the pixel side while one-bit rows keep coming
        bpp = BPP_1;
        set_config(bpp, 13'd20, 13'd2, ROT_0, 1'b0, pick_offset(), pick_offset());
        n_items = 40;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 2) bpp = BPP_1;
        else if (sel < 4) bpp = BPP_4;
        else if (sel < 6) bpp = BPP_8;
        else if (sel < 9) bpp = BPP_24;
        else bpp = 5'($urandom_range(0, 31));
        w = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(4096, 8191))
                                        : 13'($urandom_range(1, 24));
        if ($urandom_range(0, 7) == 0) h = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
        else h = 13'($urandom_range(1, 4));
        set_config(bpp, w, h, 2'($urandom_range(0, 3)), ($urandom_range(0, 7) == 0),
                   pick_offset(), pick_offset());
        n_items = $urandom_range(8, 16);
      end
      idle_off = (ph % 4 == 3);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 7) == 0)
          push_palette(8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)));
        else
          push_data((bpp == BPP_8) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255)));
      end
      if (ph == 0) pressure_go = 1'b1;
    end

    wait_idle();
    $display("Run covered %0d requests (%0d palette writes), %0d pixels, %0d register setups",
             n_reqs, n_pal, n_pixels, n_setups);
    $display("Depths 1/4/8/24 plus unsupported ones, all rotations, transparency, clamped sizes");
    if (err_count == 0) begin
      $display("[bitmap_pixel_unpack_rotate_top] OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[bitmap_pixel_unpack_rotate_top] ERROR");
    end
    $finish;
  end

endmodule

[bitmap_pixel_unpack_rotate_top.f]
+incdir+rtl
rtl/bpu_pkg.sv
rtl/bpu_cfg_regs.sv
rtl/bpu_palette_mem.sv
rtl/bpu_unpack.sv
rtl/bpu_place.sv
rtl/bitmap_pixel_unpack_rotate_top.sv
sim/testbench.sv
